FILE: hdl/odc_pkg.sv
`default_nettype none
package odc_pkg;
	localparam int DEPTH = 1024;
	localparam int VW = 16;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [2:0] V_UNSURE = 3'd0;
	localparam logic [2:0] V_HEAP = 3'd1;
	localparam logic [2:0] V_QUEUE = 3'd2;
	localparam logic [2:0] V_STACK = 3'd3;
	localparam logic [2:0] V_NONE = 3'd4;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	typedef struct packed {
		logic go;
		logic pop;
		logic [VW-1:0] val;
	} heap_cmd_t;

	typedef struct packed {
		logic done;
		logic match;
		logic overflow;
	} heap_sts_t;
endpackage
`default_nettype wire

FILE: hdl/ordering_discipline_checker_top.sv
// The verdict strobe is registered and rises after the last word leaves the check phase.
// One word is taken at a time; busy stays high while the heap sifts through memory.
// Heap pushes sift up and pops down; words that skip the heap need only the read and check phases.
// The receiver cannot stall, so a verdict never holds the input off.
// Reset clears counters and flags; store contents are undefined until written.
`default_nettype none
module ordering_discipline_checker_top
	import odc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          req_type,
	input  wire logic [15:0]   value,
	input  wire logic          last_op,
	output logic               strobe,
	output logic [2:0]         verdict,
	output logic               overflow
);
	logic [VW-1:0] fs [DEPTH];
	logic [VW-1:0] ls [DEPTH];
	logic [AW-1:0] fh_q, ft_q;
	logic [CW-1:0] fc_q, lc_q;
	logic [2:0] fl_q;
	logic ov_q, pop_q, last_q;
	logic [VW-1:0] v_q, frd_s1, lrd_s1;
	logic [1:0] ph_q;
	logic take, fin, hclr;
	logic [2:0] f;
	logic [2:0] vd;
	heap_cmd_t hcmd;
	heap_sts_t hsts;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_RD = 2'd1;
	localparam logic [1:0] P_CHK = 2'd2;

	assign busy = ph_q != P_IDLE;
	assign take = start && ph_q == P_IDLE;
	assign fin = ph_q == P_CHK && (!fl_q[0] || hsts.done);
	assign hclr = fin && last_q;

	assign hcmd.go = take && fl_q[0];
	assign hcmd.pop = req_type;
	assign hcmd.val = value;

	odc_heap u_heap (.clk, .arst_n, .cmd(hcmd), .clr(hclr), .sts(hsts));

	always_ff @(posedge clk) begin
		frd_s1 <= fs[fh_q];
		lrd_s1 <= ls[lc_q[AW-1:0] - AW'(1)];
		if (take && !req_type && fl_q[1] && fc_q != FULL)
			fs[ft_q] <= value;
		if (take && !req_type && fl_q[2] && lc_q != FULL)
			ls[lc_q[AW-1:0]] <= value;
	end

	always_comb begin
		f = fl_q;
		if (pop_q) begin
			if (!hsts.match) f[0] = 1'b0;
			if (fc_q == '0 || frd_s1 != v_q) f[1] = 1'b0;
			if (lc_q == '0 || lrd_s1 != v_q) f[2] = 1'b0;
		end
	end

	always_comb begin
		unique case (f)
			3'b000: vd = V_NONE;
			3'b001: vd = V_HEAP;
			3'b010: vd = V_QUEUE;
			3'b100: vd = V_STACK;
			default: vd = V_UNSURE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= '0; ft_q <= '0; fc_q <= '0; lc_q <= '0;
			fl_q <= 3'b111; ov_q <= 1'b0; strobe <= 1'b0;
			ph_q <= P_IDLE; verdict <= V_UNSURE; overflow <= 1'b0;
		end else begin
			strobe <= fin && last_q;
			unique case (ph_q)
				P_IDLE: if (start) begin
					ph_q <= P_RD;
					pop_q <= req_type; v_q <= value; last_q <= last_op;
					if (!req_type) begin
						if (fl_q[1] && fc_q != FULL) begin
							ft_q <= (ft_q == AW'(DEPTH - 1)) ? '0 : ft_q + AW'(1);
							fc_q <= fc_q + CW'(1);
						end
						if (fl_q[2] && lc_q != FULL) lc_q <= lc_q + CW'(1);
						ov_q <= ov_q || (fl_q[1] && fc_q == FULL) || (fl_q[2] && lc_q == FULL);
					end
				end
				P_RD: ph_q <= P_CHK;
				P_CHK: if (fin) begin
					ph_q <= P_IDLE;
					if (last_q) begin
						verdict <= vd;
						overflow <= ov_q || (fl_q[0] && hsts.overflow);
						fh_q <= '0; ft_q <= '0; fc_q <= '0; lc_q <= '0;
						fl_q <= 3'b111; ov_q <= 1'b0;
					end else begin
						if (fl_q[0] && hsts.overflow) ov_q <= 1'b1;
						if (pop_q) begin
							fl_q <= f;
							if (f[1]) begin
								fh_q <= (fh_q == AW'(DEPTH - 1)) ? '0 : fh_q + AW'(1);
								fc_q <= fc_q - CW'(1);
							end
							if (f[2]) lc_q <= lc_q - CW'(1);
						end
					end
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("verdict while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FULL && lc_q <= FULL) else $error("count overrun");
	a_heap_done: assert property (@(posedge clk) disable iff (!arst_n)
		hsts.done |-> ph_q == P_CHK) else $error("heap done while idle");
endmodule
`default_nettype wire

FILE: hdl/odc_ram.sv
`default_nettype none
module odc_ram
	import odc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [VW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [VW-1:0] rdata
);
	logic [VW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/odc_heap.sv
`default_nettype none
module odc_heap
	import odc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire heap_cmd_t cmd,
	input  wire logic      clr,
	output heap_sts_t      sts
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TOP = 4'd1;
	localparam logic [3:0] S_UPRD = 4'd2;
	localparam logic [3:0] S_UPCMP = 4'd3;
	localparam logic [3:0] S_LRD = 4'd4;
	localparam logic [3:0] S_LAST = 4'd5;
	localparam logic [3:0] S_C1 = 4'd6;
	localparam logic [3:0] S_C2 = 4'd7;
	localparam logic [3:0] S_SEL = 4'd8;
	localparam logic [3:0] S_DNCMP = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q, c_q;
	logic [VW-1:0] v_q, c1_q;
	logic pop_q, match_q, ovf_q;
	logic we;
	logic [AW-1:0] wa, ra;
	logic [VW-1:0] wd, rd;
	logic [CW-1:0] p;
	logic [CW:0] l;

	odc_ram u_ram (.clk, .we, .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

	assign p = (i_q - CW'(1)) >> 1;
	assign l = {i_q, 1'b1};

	assign sts.done = state_q == S_DONE;
	assign sts.match = match_q;
	assign sts.overflow = ovf_q;

	always_comb begin
		we = 1'b0;
		wa = i_q[AW-1:0];
		wd = v_q;
		ra = '0;
		unique case (state_q)
			S_UPRD: ra = p[AW-1:0];
			S_UPCMP: if (rd < v_q) begin
				we = 1'b1;
				wd = rd;
			end
			S_LRD: ra = cnt_q[AW-1:0];
			S_C1: ra = l[AW-1:0];
			S_C2: ra = l[AW-1:0] + AW'(1);
			S_DNCMP: if (c1_q > v_q) begin
				we = 1'b1;
				wd = c1_q;
			end
			S_FIN: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			match_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (clr) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.go) begin
					pop_q <= cmd.pop;
					v_q <= cmd.val;
					state_q <= S_TOP;
				end
				S_TOP: begin
					i_q <= pop_q ? '0 : cnt_q;
					ovf_q <= !pop_q && cnt_q == FULL;
					match_q <= pop_q && cnt_q != '0 && rd == v_q;
					if (!pop_q) begin
						if (cnt_q == FULL) state_q <= S_DONE;
						else begin
							cnt_q <= cnt_q + CW'(1);
							state_q <= (cnt_q == '0) ? S_FIN : S_UPRD;
						end
					end else if (cnt_q == '0 || rd != v_q) state_q <= S_DONE;
					else begin
						cnt_q <= cnt_q - CW'(1);
						state_q <= (cnt_q == CW'(1)) ? S_DONE : S_LRD;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (rd < v_q) begin
						i_q <= p;
						state_q <= (p == '0) ? S_FIN : S_UPRD;
					end else state_q <= S_FIN;
				end
				S_LRD: state_q <= S_LAST;
				S_LAST: begin
					v_q <= rd;
					state_q <= (l < {1'b0, cnt_q}) ? S_C1 : S_FIN;
				end
				S_C1: state_q <= S_C2;
				S_C2: begin
					c1_q <= rd;
					c_q <= l[CW-1:0];
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (c_q + CW'(1) < cnt_q && rd > c1_q) begin
						c1_q <= rd;
						c_q <= c_q + CW'(1);
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if (c1_q > v_q) begin
						i_q <= c_q;
						state_q <= ({c_q, 1'b1} < {1'b0, cnt_q}) ? S_C1 : S_FIN;
					end else state_q <= S_FIN;
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
	import odc_pkg::*;

	localparam bit [2:0] F_HEAP = 3'b001;
	localparam bit [2:0] F_QUEUE = 3'b010;
	localparam bit [2:0] F_STACK = 3'b100;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [2:0] verdict;
		logic overflow;
	} verdict_t;

	class discipline_scoreboard;
		logic [VW-1:0] fifo_mem[DEPTH];
		logic [VW-1:0] lifo_mem[DEPTH];
		logic [VW-1:0] heap_mem[DEPTH];
		int fifo_rd, fifo_wr, fifo_cnt, lifo_cnt, heap_cnt;
		bit [2:0] alive;
		bit ovf;
		verdict_t pending[$];
		int errors;

		function void clear();
			fifo_rd = 0;
			fifo_wr = 0;
			fifo_cnt = 0;
			lifo_cnt = 0;
			heap_cnt = 0;
			alive = 3'b111;
			ovf = 0;
		endfunction

		function new();
			clear();
			errors = 0;
		endfunction

		function void heap_push(logic [VW-1:0] v);
			int i, p;
			i = heap_cnt;
			heap_cnt++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (heap_mem[p] >= v)
					break;
				heap_mem[i] = heap_mem[p];
				i = p;
			end
			heap_mem[i] = v;
		endfunction

		function void heap_pop();
			logic [VW-1:0] v;
			int i, c;
			i = 0;
			heap_cnt--;
			if (heap_cnt == 0)
				return;
			v = heap_mem[heap_cnt];
			forever begin
				c = 2 * i + 1;
				if (c >= heap_cnt)
					break;
				if (c + 1 < heap_cnt && heap_mem[c + 1] > heap_mem[c])
					c++;
				if (heap_mem[c] <= v)
					break;
				heap_mem[i] = heap_mem[c];
				i = c;
			end
			heap_mem[i] = v;
		endfunction

		function void note_word(logic is_pop, logic [VW-1:0] v, logic is_last);
			verdict_t e;
			int n;
			if (!is_pop) begin
				if (alive & F_HEAP) begin
					if (heap_cnt >= DEPTH) ovf = 1;
					else heap_push(v);
				end
				if (alive & F_QUEUE) begin
					if (fifo_cnt >= DEPTH) ovf = 1;
					else begin
						fifo_mem[fifo_wr] = v;
						fifo_wr = (fifo_wr + 1) % DEPTH;
						fifo_cnt++;
					end
				end
				if (alive & F_STACK) begin
					if (lifo_cnt >= DEPTH) ovf = 1;
					else begin
						lifo_mem[lifo_cnt] = v;
						lifo_cnt++;
					end
				end
			end else begin
				if ((alive & F_HEAP) && (heap_cnt == 0 || heap_mem[0] != v))
					alive &= ~F_HEAP;
				if ((alive & F_QUEUE) && (fifo_cnt == 0 || fifo_mem[fifo_rd] != v))
					alive &= ~F_QUEUE;
				if ((alive & F_STACK) && (lifo_cnt == 0 || lifo_mem[lifo_cnt - 1] != v))
					alive &= ~F_STACK;
				if (alive & F_HEAP)
					heap_pop();
				if (alive & F_QUEUE) begin
					fifo_rd = (fifo_rd + 1) % DEPTH;
					fifo_cnt--;
				end
				if (alive & F_STACK)
					lifo_cnt--;
			end
			if (!is_last)
				return;
			n = alive[0] + alive[1] + alive[2];
			if (n > 1) e.verdict = V_UNSURE;
			else if (alive & F_HEAP) e.verdict = V_HEAP;
			else if (alive & F_QUEUE) e.verdict = V_QUEUE;
			else if (alive & F_STACK) e.verdict = V_STACK;
			else e.verdict = V_NONE;
			e.overflow = ovf;
			pending = {pending, e};
			clear();
		endfunction

		function void check_verdict(logic [2:0] v, logic o);
			verdict_t e;
			if (pending.size() == 0) begin
				$error("verdict word arrived with none expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.verdict) begin
				$error("verdict: expected %0d, actual %0d", e.verdict, v);
				errors++;
			end
			if (o !== e.overflow) begin
				$error("overflow: expected %0d, actual %0d", e.overflow, o);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic req_type = 0;
	logic [15:0] value = 0;
	logic last_op = 0;
	logic busy, strobe, overflow;
	logic [2:0] verdict;

	discipline_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;

	ordering_discipline_checker_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .value(value), .last_op(last_op),
		.strobe(strobe), .verdict(verdict), .overflow(overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(req_type, value, last_op);
			if (strobe)
				sb.check_verdict(verdict, overflow);
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(logic is_pop, logic [15:0] v, logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1;
		req_type <= is_pop;
		value <= v;
		last_op <= is_last;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_val(int vmax);
		return 16'($urandom_range(0, vmax));
	endfunction

	// kind: 0 heap, 1 queue, 2 stack, 3 noise
	task automatic run_trace(int kind, int len, int vmax);
		logic [15:0] held[$];
		logic [15:0] v;
		logic is_pop;
		int k, best;
		for (int i = 0; i < len; i++) begin
			is_pop = (kind == 3) ? 1'($urandom_range(0, 1))
				: (held.size() > 0 && $urandom_range(0, 1) != 0);
			if (!is_pop || kind == 3 || held.size() == 0) begin
				v = rand_val(vmax);
				if (!is_pop)
					held = {held, v};
			end else begin
				if (kind == 1) k = 0;
				else if (kind == 2) k = held.size() - 1;
				else begin
					best = 0;
					for (int j = 1; j < held.size(); j++)
						if (held[j] > held[best]) best = j;
					k = best;
				end
				v = held[k];
				held.delete(k);
				if ($urandom_range(0, 19) == 0)
					v = rand_val(65535);
			end
			send(is_pop, v, i == len - 1);
		end
	endtask

	initial begin
		int sent;
		int len, vm;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send(1'b1, 16'h0000, 1'b1);
		send(1'b0, 16'hffff, 1'b1);
		send(1'b0, 16'h0001, 1'b0);
		send(1'b0, 16'h0002, 1'b0);
		send(1'b1, 16'h0002, 1'b1);
		send(1'b0, 16'h0001, 1'b0);
		send(1'b0, 16'h0002, 1'b0);
		send(1'b1, 16'h0001, 1'b1);
		send(1'b0, 16'h0003, 1'b0);
		send(1'b0, 16'h0001, 1'b0);
		send(1'b0, 16'h0002, 1'b0);
		send(1'b1, 16'h0003, 1'b1);
		send(1'b0, 16'h0005, 1'b0);
		send(1'b0, 16'h0005, 1'b0);
		send(1'b1, 16'h0005, 1'b0);
		send(1'b1, 16'h0005, 1'b1);
		send(1'b0, 16'haaaa, 1'b0);
		send(1'b1, 16'h5555, 1'b1);
		send(1'b0, 16'h0000, 1'b0);
		send(1'b1, 16'h0000, 1'b0);
		send(1'b1, 16'h0000, 1'b1);

		for (int i = 0; i < DEPTH + 3; i++)
			send(1'b0, rand_val(65535), 1'b0);
		send(1'b1, 16'hffff, 1'b1);

		sent = 0;
		while (sent < 650) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			case ($urandom_range(0, 2))
				0: vm = 3;
				1: vm = 255;
				default: vm = 65535;
			endcase
			run_trace(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2), len, vm);
			sent += len;
		end
		start <= 0;

		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
hdl/odc_pkg.sv
hdl/odc_ram.sv
hdl/odc_heap.sv
hdl/ordering_discipline_checker_top.sv
test/tb.sv
